/* rtl/sm3_hash_engine_defines.svh */
// Assertion macros shared by the SM3 hash engine RTL.
`ifndef SM3_HASH_ENGINE_DEFINES_SVH
`define SM3_HASH_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a consequent in the same cycle as its antecedent.
`define SM3_ASSERT_SAME(lbl, clk_i, rst_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error("sm3 assertion failed");

// Check a consequent in the cycle after its antecedent.
`define SM3_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("sm3 assertion failed");

`else

`define SM3_ASSERT_SAME(lbl, clk_i, rst_i, ante, cons)
`define SM3_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons)

`endif

`endif

/* rtl/sm3_pkg.sv */
// Types, constants and bit functions of the SM3 hash engine.
`timescale 1ns / 1ps

package sm3_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_done;
  } dig_t;

  localparam logic [7:0][31:0] SM3_IV = {
    32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
    32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
  };

  localparam logic [31:0] SM3_T_LOW      = 32'h79cc4519;
  localparam logic [31:0] SM3_T_HIGH     = 32'h7a879d8a;
  localparam logic [31:0] SM3_T_HIGH_R16 = {SM3_T_HIGH[15:0], SM3_T_HIGH[31:16]};
  localparam logic [7:0]  SM3_PAD        = 8'h80;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
    int unsigned m;
    m = n & 31;
    if (m == 0) begin
      return x;
    end
    return (x << m) | (x >> (32 - m));
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl32(x, 9) ^ rotl32(x, 17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl32(x, 15) ^ rotl32(x, 23);
  endfunction

endpackage

/* rtl/sm3_hash_engine.sv */
// SM3 hash engine: word collection, padding, expansion and round loop.
`timescale 1ns / 1ps
// Usage:
//   Requests enter on msg (message_word, valid_bytes, last_word) with
//   msg_valid/msg_ready. Every word but the last carries four bytes; the
//   last word carries valid_bytes leading bytes (0..4, larger counts as 4).
//   Digest words leave on dig (digest_word, word_index, digest_done) with
//   dig_valid/dig_ready, eight of them, most significant first, after a
//   last word only.
// Timing:
//   Words are taken one a cycle while msg_ready is high. Every sixteenth
//   word starts a compression of 64 rounds, one round a cycle in a single
//   round unit, during which msg_ready is low. After the last word the
//   padding words (up to 18) go in one a cycle outside compressions, with
//   one or two compressions before the first digest word shows; the eight
//   words then leave at one a cycle while dig_ready is high.
// Reset and stalls:
//   rst (synchronous) loads the IV and clears length and fill. While dig is
//   stalled the digest word holds and no request is taken; after the eighth
//   word is taken the IV reloads and msg_ready rises.
`include "sm3_hash_engine_defines.svh"

module sm3_hash_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          msg_valid,
  output logic          msg_ready,
  input  sm3_pkg::msg_t msg,
  output logic          dig_valid,
  input  logic          dig_ready,
  output sm3_pkg::dig_t dig
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_COMP = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam logic [1:0] PH_PAD80 = 2'd0;
  localparam logic [1:0] PH_ZERO  = 2'd1;
  localparam logic [1:0] PH_LENLO = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [1:0]        phase;
  logic [1:0]        phase_next;
  logic              finishing;
  logic [3:0]        fill;
  logic [5:0]        round_index;
  logic [63:0]       bit_length;
  logic [7:0][31:0]  cv;
  logic [7:0][31:0]  rr;
  logic [7:0][31:0]  rr_next;
  logic [15:0][31:0] window;
  logic [31:0]       tj;
  logic [2:0]        out_idx;

  logic              push_en;
  logic [31:0]       push_data;
  logic [2:0]        nbytes;
  logic [31:0]       last_data;
  logic [63:0]       len_inc;
  logic [31:0]       w_new;
  logic              accept;

  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] ff, gg, a12, ss1, ss2, tt1, tt2;

  assign accept    = msg_valid && msg_ready;
  assign msg_ready = (state == ST_IDLE);
  assign dig_valid = (state == ST_OUT);

  always_comb begin
    dig.digest_word = cv[out_idx];
    dig.word_index  = out_idx;
    dig.digest_done = (out_idx == 3'd7);
  end

  always_comb begin
    if (!msg.last_word || msg.valid_bytes > 3'd4) begin
      nbytes = 3'd4;
    end else begin
      nbytes = msg.valid_bytes;
    end
    unique case (nbytes)
      3'd0:    last_data = {sm3_pkg::SM3_PAD, 24'h0};
      3'd1:    last_data = {msg.message_word[31:24], sm3_pkg::SM3_PAD, 16'h0};
      3'd2:    last_data = {msg.message_word[31:16], sm3_pkg::SM3_PAD, 8'h0};
      3'd3:    last_data = {msg.message_word[31:8], sm3_pkg::SM3_PAD};
      default: last_data = msg.message_word;
    endcase
    len_inc = {58'h0, nbytes, 3'b000};
  end

  always_comb begin
    push_en    = 1'b0;
    push_data  = '0;
    state_next = state;
    phase_next = phase;
    unique case (state)
      ST_IDLE: begin
        if (msg_valid) begin
          push_en   = 1'b1;
          push_data = last_data;
          if (msg.last_word) begin
            phase_next = (nbytes == 3'd4) ? PH_PAD80 : PH_ZERO;
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        unique case (phase)
          PH_PAD80: begin
            push_data  = {sm3_pkg::SM3_PAD, 24'h0};
            phase_next = PH_ZERO;
          end
          PH_ZERO: begin
            if (fill == 4'd14) begin
              push_data  = bit_length[63:32];
              phase_next = PH_LENLO;
            end
          end
          PH_LENLO: begin
            push_data  = bit_length[31:0];
            phase_next = PH_DONE;
          end
          PH_DONE: begin
            push_en = 1'b0;
          end
        endcase
      end
      ST_COMP: begin
        if (round_index == 6'd63) begin
          if (!finishing) begin
            state_next = ST_IDLE;
          end else if (phase == PH_DONE) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_PAD;
          end
        end
      end
      ST_OUT: begin
        if (dig_ready && out_idx == 3'd7) begin
          state_next = ST_IDLE;
        end
      end
    endcase
    if (push_en && fill == 4'd15) begin
      state_next = ST_COMP;
    end
  end

  always_comb begin
    a = rr[0];
    b = rr[1];
    c = rr[2];
    d = rr[3];
    e = rr[4];
    f = rr[5];
    g = rr[6];
    h = rr[7];
    if (round_index[5:4] == 2'b00) begin
      ff = a ^ b ^ c;
      gg = e ^ f ^ g;
    end else begin
      ff = (a & b) | (b & c) | (a & c);
      gg = (e & f) | (~e & g);
    end
    a12 = sm3_pkg::rotl32(a, 12);
    ss1 = sm3_pkg::rotl32(a12 + e + tj, 7);
    ss2 = ss1 ^ a12;
    tt1 = ff + d + ss2 + (window[0] ^ window[4]);
    tt2 = gg + h + ss1 + window[0];
    rr_next[0] = tt1;
    rr_next[1] = a;
    rr_next[2] = sm3_pkg::rotl32(b, 9);
    rr_next[3] = c;
    rr_next[4] = sm3_pkg::perm0(tt2);
    rr_next[5] = e;
    rr_next[6] = sm3_pkg::rotl32(f, 19);
    rr_next[7] = g;
    w_new = sm3_pkg::perm1(window[0] ^ window[7] ^ sm3_pkg::rotl32(window[13], 15))
            ^ sm3_pkg::rotl32(window[3], 7) ^ window[10];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_DONE;
      finishing   <= 1'b0;
      fill        <= '0;
      round_index <= '0;
      bit_length  <= '0;
      cv          <= sm3_pkg::SM3_IV;
      out_idx     <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (accept) begin
        bit_length <= bit_length + len_inc;
        if (msg.last_word) begin
          finishing <= 1'b1;
        end
      end
      if (push_en) begin
        fill <= fill + 4'd1;
      end
      if (state == ST_COMP) begin
        round_index <= round_index + 6'd1;
        if (round_index == 6'd63) begin
          for (int i = 0; i < 8; i++) begin
            cv[i] <= cv[i] ^ rr_next[i];
          end
        end
      end
      if (state == ST_OUT && dig_ready) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == 3'd7) begin
          cv         <= sm3_pkg::SM3_IV;
          bit_length <= '0;
          finishing  <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      window <= {push_data, window[15:1]};
      if (fill == 4'd15) begin
        rr <= cv;
        tj <= sm3_pkg::SM3_T_LOW;
      end
    end else if (state == ST_COMP) begin
      window <= {w_new, window[15:1]};
      rr     <= rr_next;
      tj     <= (round_index == 6'd15) ? sm3_pkg::SM3_T_HIGH_R16 : sm3_pkg::rotl32(tj, 1);
    end
  end

  `SM3_ASSERT_SAME(a_round_idle, clk, rst, state != ST_COMP, round_index == 6'd0)
  `SM3_ASSERT_SAME(a_comp_fill, clk, rst, state == ST_COMP, fill == 4'd0)
  `SM3_ASSERT_SAME(a_idle_clean, clk, rst, state == ST_IDLE, !finishing)
  `SM3_ASSERT_NEXT(a_iv_reload, clk, rst, dig_valid && dig_ready && dig.digest_done,
    msg_ready && bit_length == 64'h0 && cv == sm3_pkg::SM3_IV)

endmodule

/* verif/sm3_hash_engine_tb.sv */
// Testbench for the SM3 hash engine: directed vectors and random messages checked by a predictor.
`timescale 1ns / 1ps

module sm3_hash_engine_tb;

  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned RANDOM_ITEMS   = 190;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned TAIL_CYCLES    = 160;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct {
    sm3_pkg::msg_t req;
    bit            known;
    logic [255:0]  digest;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic msg_valid = 1'b0;
  logic msg_ready;
  sm3_pkg::msg_t msg = '0;
  logic dig_valid;
  logic dig_ready = 1'b0;
  sm3_pkg::dig_t dig;

  logic [31:0] chain_words [8];
  logic [31:0] block_words [16];
  logic [63:0] message_bits;
  int unsigned block_fill;

  sm3_pkg::dig_t digest_expect_q [$];
  stim_row_t     directed_rows [$];
  int unsigned   mismatches = 0;
  int unsigned   requests_sent = 0;
  int unsigned   send_idle_pct = 13;
  int unsigned   recv_idle_pct = 80;
  bit            hold_req = 1'b0;
  bit            hold_done = 1'b0;
  int unsigned   quiet_cycles;

  sm3_hash_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig       (dig)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] rotate_left(input logic [31:0] x, input int unsigned n);
    logic [63:0] twice;
    twice = {x, x} << (n % 32);
    return twice[63:32];
  endfunction

  function automatic logic [31:0] mix_p0(input logic [31:0] x);
    return x ^ rotate_left(x, 9) ^ rotate_left(x, 17);
  endfunction

  function automatic logic [31:0] mix_p1(input logic [31:0] x);
    return x ^ rotate_left(x, 15) ^ rotate_left(x, 23);
  endfunction

  function automatic void reload_chain();
    for (int k = 0; k < 8; k++) begin
      chain_words[k] = sm3_pkg::SM3_IV[k];
    end
    message_bits = '0;
    block_fill = 0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] tj, ff, gg, ss1, ss2, tt1, tt2;
    for (int j = 0; j < 16; j++) begin
      w[j] = block_words[j];
    end
    for (int j = 16; j < 68; j++) begin
      w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rotate_left(w[j-3], 15))
             ^ rotate_left(w[j-13], 7) ^ w[j-6];
    end
    {a, b, c, d} = {chain_words[0], chain_words[1], chain_words[2], chain_words[3]};
    {e, f, g, h} = {chain_words[4], chain_words[5], chain_words[6], chain_words[7]};
    for (int j = 0; j < 64; j++) begin
      if (j < 16) begin
        tj = sm3_pkg::SM3_T_LOW;
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        tj = sm3_pkg::SM3_T_HIGH;
        ff = (a & b) | (b & c) | (a & c);
        gg = (e & f) | (~e & g);
      end
      ss1 = rotate_left(rotate_left(a, 12) + e + rotate_left(tj, j), 7);
      ss2 = ss1 ^ rotate_left(a, 12);
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c;
      c = rotate_left(b, 9);
      b = a;
      a = tt1;
      h = g;
      g = rotate_left(f, 19);
      f = e;
      e = mix_p0(tt2);
    end
    chain_words[0] ^= a;
    chain_words[1] ^= b;
    chain_words[2] ^= c;
    chain_words[3] ^= d;
    chain_words[4] ^= e;
    chain_words[5] ^= f;
    chain_words[6] ^= g;
    chain_words[7] ^= h;
  endfunction

  function automatic void absorb_word(input logic [31:0] wd);
    block_words[block_fill] = wd;
    block_fill++;
    if (block_fill == 16) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  function automatic bit hash_request(input sm3_pkg::msg_t r, output logic [255:0] digest);
    int unsigned nbytes;
    logic [31:0] keep;
    digest = '0;
    if (!r.last_word) begin
      message_bits += 64'd32;
      absorb_word(r.message_word);
      return 1'b0;
    end
    nbytes = (r.valid_bytes > 3'd4) ? 4 : r.valid_bytes;
    message_bits += 64'(8 * nbytes);
    if (nbytes == 4) begin
      absorb_word(r.message_word);
      absorb_word({sm3_pkg::SM3_PAD, 24'h0});
    end else begin
      keep = (nbytes == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * nbytes));
      absorb_word((r.message_word & keep) | ({24'h0, sm3_pkg::SM3_PAD} << (24 - 8 * nbytes)));
    end
    if (block_fill > 14) begin
      while (block_fill != 0) begin
        absorb_word(32'h0);
      end
    end
    while (block_fill < 14) begin
      absorb_word(32'h0);
    end
    absorb_word(message_bits[63:32]);
    absorb_word(message_bits[31:0]);
    for (int k = 0; k < 8; k++) begin
      digest[255 - 32 * k -: 32] = chain_words[k];
    end
    reload_chain();
    return 1'b1;
  endfunction

  function automatic void add_row(input logic [31:0] wd, input logic [2:0] nb, input logic last,
                                  input bit known, input logic [255:0] digest);
    stim_row_t row;
    row.req.message_word = wd;
    row.req.valid_bytes  = nb;
    row.req.last_word    = last;
    row.known            = known;
    row.digest           = digest;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input sm3_pkg::msg_t r, input bit known,
                              input logic [255:0] known_digest);
    logic [255:0]  digest;
    sm3_pkg::dig_t word;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      msg_valid <= 1'b0;
      msg       <= '{message_word: $urandom, valid_bytes: 3'($urandom), last_word: 1'($urandom)};
      @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg       <= r;
    @(posedge clk);
    while (!msg_ready) begin
      @(posedge clk);
    end
    requests_sent++;
    if (hash_request(r, digest)) begin
      if (known) begin
        digest = known_digest;
      end
      for (int k = 0; k < 8; k++) begin
        word.digest_word = digest[255 - 32 * k -: 32];
        word.word_index  = 3'(k);
        word.digest_done = (k == 7);
        digest_expect_q.push_back(word);
      end
    end
  endtask

  task automatic send_random_message();
    int unsigned   body_len;
    int unsigned   pick;
    sm3_pkg::msg_t r;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      body_len = 16 * $urandom_range(0, 1) + $urandom_range(12, 15);
    end else if (pick < 9) begin
      body_len = $urandom_range(0, 11);
    end else begin
      body_len = $urandom_range(32, 40);
    end
    for (int i = 0; i < body_len; i++) begin
      r.message_word = random_word();
      r.valid_bytes  = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      r.last_word    = 1'b0;
      send_request(r, 1'b0, '0);
    end
    r.message_word = random_word();
    r.valid_bytes  = 3'($urandom_range(0, 7));
    r.last_word    = 1'b1;
    send_request(r, 1'b0, '0);
  endtask

  function automatic void check_digest_word(input sm3_pkg::dig_t got);
    sm3_pkg::dig_t want;
    if (digest_expect_q.size() == 0) begin
      $display("%0t: digest word with none expected: expected none, actual %h idx %0d done %0b",
               $time, got.digest_word, got.word_index, got.digest_done);
      mismatches++;
      return;
    end
    want = digest_expect_q.pop_front();
    if (got.digest_word !== want.digest_word) begin
      $display("%0t: digest_word expected %h actual %h", $time, want.digest_word,
               got.digest_word);
      mismatches++;
    end
    if (got.word_index !== want.word_index) begin
      $display("%0t: word_index expected %0d actual %0d", $time, want.word_index,
               got.word_index);
      mismatches++;
    end
    if (got.digest_done !== want.digest_done) begin
      $display("%0t: digest_done expected %0b actual %0b", $time, want.digest_done,
               got.digest_done);
      mismatches++;
    end
  endfunction

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && dig_valid && dig_ready) begin
        check_digest_word(dig);
      end
      if (hold_req && !hold_done) begin
        dig_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      dig_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (msg_valid && msg_ready) || (dig_valid && dig_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned random_base;
    reload_chain();
    add_row(32'h61626300, 3'd3, 1'b1, 1'b1,
            256'h66c7f0f462eeedd9d1f2d46bdc10e4e24167c4875cf2f7a2297da02b8f4ba8e0);
    for (int i = 0; i < 15; i++) begin
      add_row(32'h61626364, 3'd4, 1'b0, 1'b0, '0);
    end
    add_row(32'h61626364, 3'd4, 1'b1, 1'b1,
            256'hdebe9ff92275b8a138604889c18e5a4d6fdb70e5387e5765293dcba39c0c5732);
    add_row(32'hffffffff, 3'd0, 1'b1, 1'b0, '0);
    add_row(32'hffffffff, 3'd7, 1'b1, 1'b0, '0);
    add_row(32'h00000000, 3'd0, 1'b0, 1'b0, '0);
    add_row(32'hffffffff, 3'd5, 1'b0, 1'b0, '0);
    add_row(32'h12345678, 3'd6, 1'b1, 1'b0, '0);
    add_row(32'hffffffff, 3'd4, 1'b1, 1'b0, '0);
    add_row(32'ha5a5a5a5, 3'd2, 1'b1, 1'b0, '0);
    add_row(32'h5a5a5a5a, 3'd1, 1'b1, 1'b0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].known, directed_rows[i].digest);
    end

    random_base = requests_sent;
    while (requests_sent - random_base < RANDOM_ITEMS) begin
      if (requests_sent - random_base >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
      end else if (requests_sent - random_base >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 80;
        recv_idle_pct = 13;
      end
      send_random_message();
    end
    msg_valid <= 1'b0;

    while (digest_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && digest_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
